// ===== rtl/ppmfd_pkg.sv =====
package ppmfd_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LINK_BYTES = 6;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [7:0] LINK_NONE = 8'hFF;
  localparam logic [7:0] VALUE_MAX = 8'd254;
  localparam logic [31:0] WIDTH_RESET = 32'd128;
  localparam logic [7:0] VALUE_RESET = 8'd128;
  localparam logic [7:0] FWD_RESET = 8'hFF;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PPM_ENABLE,
    REG_SYNC_GAP_TICKS,
    REG_MIN_PULSE_TICKS,
    REG_MAX_PULSE_TICKS,
    REG_ZERO_TICKS,
    REG_SCALE_Q16,
    REG_DEADBAND,
    REG_LINK_MAP
  } reg_idx_t;

  typedef struct packed {
    logic        ppm_enable;
    logic [31:0] sync_gap_ticks;
    logic [31:0] min_pulse_ticks;
    logic [31:0] max_pulse_ticks;
    logic [31:0] zero_ticks;
    logic [31:0] scale_q16;
    logic [7:0]  deadband;
    logic [47:0] link_map;
  } cfg_t;

  typedef enum logic {
    CMD_EDGE,
    CMD_CHECK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        level;
    logic [31:0] ts;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_SYNC,
    PH_WAIT,
    PH_PULSE
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_MUL,
    B_UPDATE,
    B_EMIT
  } bstate_t;

endpackage

// ===== rtl/ppmfd_ifs.sv =====
interface ppmfd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        pin_level;
  logic [31:0] timestamp;

  modport source(output valid, func, pin_level, timestamp, input ready);
  modport sink(input valid, func, pin_level, timestamp, output ready);
endinterface

interface ppmfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] channel;
  logic [7:0] value;
  logic [7:0] link_target;
  logic       send_link;
  logic       last;

  modport source(output valid, channel, value, link_target, send_link, last, input ready);
  modport sink(input valid, channel, value, link_target, send_link, last, output ready);
endinterface

// ===== rtl/ppmfd_front.sv =====
module ppmfd_front (
  ppmfd_in_if.sink       item,
  input  ppmfd_pkg::cfg_t cfg,
  input  logic            q_full,
  output logic            q_push,
  output ppmfd_pkg::cmd_t q_cmd
);
  import ppmfd_pkg::*;

  logic accept;

  assign item.ready = !q_full;
  assign accept = item.valid && !q_full;

  // A check while the pin is not in PPM mode has no effect, so it is dropped here.
  always_comb begin
    q_cmd.kind = item.func ? CMD_CHECK : CMD_EDGE;
    q_cmd.level = item.pin_level;
    q_cmd.ts = item.timestamp;
    q_push = accept && (!item.func || cfg.ppm_enable);
  end

endmodule

// ===== rtl/ppmfd_queue.sv =====
module ppmfd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppmfd_pkg::cmd_t din,
  output logic            full,
  input  logic            pop,
  output ppmfd_pkg::cmd_t dout,
  output logic            empty
);
  import ppmfd_pkg::*;

  cmd_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ppmfd_back.sv =====
module ppmfd_back (
  input  logic            clk,
  input  logic            rst,
  input  ppmfd_pkg::cfg_t cfg,
  input  logic            q_empty,
  input  ppmfd_pkg::cmd_t q_cmd,
  output logic            q_pop,
  ppmfd_out_if.source     result
);
  import ppmfd_pkg::*;

  phase_t            phase;
  logic [31:0]       gap_start;
  logic              gap_armed;
  logic [CH_W-1:0]   chan_index;
  logic [31:0]       pulse_start;
  logic [31:0]       raw_width [NUM_CHANNELS];
  logic [7:0]        chan_value [NUM_CHANNELS];
  logic [7:0]        last_fwd [NUM_CHANNELS];
  logic [7:0]        link_byte [NUM_CHANNELS];

  bstate_t           state;
  bstate_t           state_next;
  logic [CH_W-1:0]   ch;
  logic              moved;
  logic [31:0]       diff;
  logic              in_rng;
  logic              above;
  logic [63:0]       prod;
  logic              prod_rng;

  logic              out_valid;
  logic [2:0]        out_channel;
  logic [7:0]        out_value;
  logic [7:0]        out_link;
  logic              out_send;
  logic              out_last;

  logic              is_edge;
  logic              start_chk;
  logic              do_read;
  logic              do_mul;
  logic              do_update;
  logic              emit;
  logic              last_ch;
  logic [31:0]       gap_base;
  logic [7:0]        scaled;
  logic [7:0]        delta;
  logic              hit;
  logic [7:0]        tgt;
  logic              send;

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_link
    if (i < LINK_BYTES) begin : g_mapped
      assign link_byte[i] = cfg.link_map[8*i +: 8];
    end else begin : g_unmapped
      assign link_byte[i] = LINK_NONE;
    end
  end

  assign last_ch = (ch == CH_W'(NUM_CHANNELS - 1));

  always_comb begin
    q_pop = 1'b0;
    is_edge = 1'b0;
    start_chk = 1'b0;
    do_read = 1'b0;
    do_mul = 1'b0;
    do_update = 1'b0;
    emit = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop = !q_empty;
        is_edge = !q_empty && (q_cmd.kind == CMD_EDGE);
        start_chk = !q_empty && (q_cmd.kind == CMD_CHECK);
      end
      B_READ: do_read = 1'b1;
      B_MUL: do_mul = 1'b1;
      B_UPDATE: do_update = 1'b1;
      B_EMIT: emit = !out_valid || result.ready;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (start_chk) begin
          state_next = B_READ;
        end
      end
      B_READ: state_next = B_MUL;
      B_MUL: state_next = B_UPDATE;
      B_UPDATE: begin
        if (!last_ch) begin
          state_next = B_READ;
        end else if (moved || hit) begin
          state_next = B_EMIT;
        end else begin
          state_next = B_IDLE;
        end
      end
      B_EMIT: begin
        if (emit && last_ch) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The sync gap is measured from the edge itself when no start is latched yet or the edge is low.
  assign gap_base = (!gap_armed || !q_cmd.level) ? q_cmd.ts : gap_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      gap_start <= '0;
      gap_armed <= 1'b0;
      chan_index <= '0;
      pulse_start <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        raw_width[i] <= WIDTH_RESET;
      end
    end else if (is_edge) begin
      case (phase)
        PH_WAIT: begin
          if (!q_cmd.level) begin
            pulse_start <= q_cmd.ts;
            phase <= PH_PULSE;
          end
        end
        PH_PULSE: begin
          if (q_cmd.level) begin
            raw_width[chan_index] <= q_cmd.ts - pulse_start;
            if (chan_index == CH_W'(NUM_CHANNELS - 1)) begin
              chan_index <= '0;
              phase <= PH_SYNC;
            end else begin
              chan_index <= chan_index + 1'b1;
              phase <= PH_WAIT;
            end
          end
        end
        default: begin
          if (!gap_armed || !q_cmd.level) begin
            gap_start <= q_cmd.ts;
            gap_armed <= 1'b1;
          end
          if (q_cmd.level && ((q_cmd.ts - gap_base) > cfg.sync_gap_ticks)) begin
            phase <= PH_WAIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      in_rng <= (raw_width[ch] > cfg.min_pulse_ticks) && (raw_width[ch] < cfg.max_pulse_ticks);
      above <= raw_width[ch] > cfg.zero_ticks;
      diff <= raw_width[ch] - cfg.zero_ticks;
    end
    if (do_mul) begin
      prod <= above ? (64'(diff) * 64'(cfg.scale_q16)) : '0;
      prod_rng <= in_rng;
    end
  end

  always_comb begin
    scaled = (prod[63:16] > 48'(VALUE_MAX)) ? VALUE_MAX : prod[23:16];
    delta = (scaled > chan_value[ch]) ? (scaled - chan_value[ch]) : (chan_value[ch] - scaled);
    hit = do_update && prod_rng && (delta > cfg.deadband);
    tgt = link_byte[ch];
    send = (tgt != LINK_NONE) && (last_fwd[ch] != chan_value[ch]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
      moved <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_value[i] <= VALUE_RESET;
        last_fwd[i] <= FWD_RESET;
      end
    end else begin
      if (start_chk) begin
        ch <= '0;
        moved <= 1'b0;
      end
      if (hit) begin
        chan_value[ch] <= scaled;
        moved <= 1'b1;
      end
      if (do_update) begin
        ch <= last_ch ? '0 : ch + 1'b1;
      end
      if (emit) begin
        if (send) begin
          last_fwd[ch] <= chan_value[ch];
        end
        ch <= last_ch ? '0 : ch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_channel <= 3'(ch);
      out_value <= chan_value[ch];
      out_link <= tgt;
      out_send <= send;
      out_last <= last_ch;
    end
  end

  assign result.valid = out_valid;
  assign result.channel = out_channel;
  assign result.value = out_value;
  assign result.link_target = out_link;
  assign result.send_link = out_send;
  assign result.last = out_last;

endmodule

// ===== rtl/ppm_frame_decoder_core.sv =====
// Channel   Direction  Transaction
// item      in         one pin edge (func 0) or one periodic check (func 1)
// result    out        one decoded channel; a run of NUM_CHANNELS ends with last set
// cfg_*     in         register write, taken on any cycle with cfg_we high
//
// An edge is decoded in the same cycle that it leaves the two-entry command queue.
// A check scans each stored width in turn through the shared multiplier (READ, MUL, UPDATE),
// then, if any value changed, emits one result per cycle while result.ready is high.
// Reset is synchronous; it restores the config, the queue pointers and all channel state.
// Items keep being taken while the queue has room, even when result is stalled.
module ppm_frame_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ppmfd_pkg::REG_IDX_W-1:0]      cfg_idx,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  ppmfd_in_if.sink                             item,
  ppmfd_out_if.source                          result
);
  import ppmfd_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  cmd_t q_out;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ppm_enable <= 1'b1;
      cfg.sync_gap_ticks <= 32'd6000;
      cfg.min_pulse_ticks <= 32'd900;
      cfg.max_pulse_ticks <= 32'd2200;
      cfg.zero_ticks <= 32'd990;
      cfg.scale_q16 <= 32'd16712;
      cfg.deadband <= 8'd3;
      cfg.link_map <= '1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_PPM_ENABLE: cfg.ppm_enable <= cfg_data[0];
        REG_SYNC_GAP_TICKS: cfg.sync_gap_ticks <= cfg_data[31:0];
        REG_MIN_PULSE_TICKS: cfg.min_pulse_ticks <= cfg_data[31:0];
        REG_MAX_PULSE_TICKS: cfg.max_pulse_ticks <= cfg_data[31:0];
        REG_ZERO_TICKS: cfg.zero_ticks <= cfg_data[31:0];
        REG_SCALE_Q16: cfg.scale_q16 <= cfg_data[31:0];
        REG_DEADBAND: cfg.deadband <= cfg_data[7:0];
        REG_LINK_MAP: cfg.link_map <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  ppmfd_front u_front (
    .item   (item),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  ppmfd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  ppmfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_cmd   (q_out),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

// ===== rtl/ppmfd_checker.sv =====
module ppmfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [2:0] channel,
  input logic [7:0] value,
  input logic [7:0] link_target,
  input logic       send_link,
  input logic       last
);
  import ppmfd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(channel) && $stable(value) && $stable(last))
    else $error("Stalled result transaction changed.");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> value <= VALUE_MAX)
    else $error("Channel value above its maximum.");

  a_send_linked: assert property (@(posedge clk) disable iff (rst)
    valid && send_link |-> link_target != LINK_NONE)
    else $error("Forward flagged for an unlinked channel.");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last == (channel == 3'(NUM_CHANNELS - 1))))
    else $error("Last flag does not match the final channel.");

endmodule

bind ppm_frame_decoder_core ppmfd_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .channel     (result.channel),
  .value       (result.value),
  .link_target (result.link_target),
  .send_link   (result.send_link),
  .last        (result.last)
);
